// File: sv/drml_pkg.sv
// Package for the dirty-region merge list: sizes, opcodes and cell types.
`timescale 1ns / 1ps
package drml_pkg;
  localparam int MaxRegions = 16;
  localparam int IdxW = $clog2(MaxRegions);
  localparam int CntW = $clog2(MaxRegions + 1);
  localparam int CoordW = 16;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpRead = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
  } rect_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic clear;
    logic append;
  } cell_ctrl_t;
endpackage

// File: sv/dirty_region_merge_list.sv
// Top level of the dirty-region merge list: cell chain and sequencer.
//
//  channel | dir | content
//  s_axis  | in  | tdata: opcode, left_x, top_y, right_x, bottom_y, read_index
//  m_axis  | out | tdata: accepted, entry_count, out_left_x..out_bottom_y
//  cfg     | in  | capacity_limit
//
// An add folds in one overlapping cell per merge step until none is left; reads and clears skip the merge.
// The merge loop is bound by the single-hit-per-cycle priority pick over the cells.
// Reset empties the list and sets capacity to 16.
// A waiting result in the output register blocks new input only until taken.
`timescale 1ns / 1ps
module dirty_region_merge_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], left_x[17:2], top_y[33:18], right_x[49:34], bottom_y[65:50],
  // read_index[69:66], zero pad to 72 bits
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // accepted[0], entry_count[5:1], out_left_x[21:6], out_top_y[37:22],
  // out_right_x[53:38], out_bottom_y[69:54], zero pad to 72 bits
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);
  import drml_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMerge = 3'b010,
    StDone = 3'b100
  } state_t;

  state_t state;
  logic [4:0] capacity;
  logic [1:0] op;
  logic [IdxW-1:0] rd_idx;
  rect_t probe;
  rect_t cell_rect [MaxRegions];
  logic [MaxRegions-1:0] cell_valid, cell_hit, shift_en, take_up;
  logic [MaxRegions-1:0] append_here;
  cell_ctrl_t ctrl;
  logic any_hit;
  logic hit_seen;
  rect_t hit_rect;
  logic [CntW-1:0] count;
  logic [CntW-1:0] cap_eff;
  logic can_store;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  assign cap_eff = (capacity > 5'(MaxRegions)) ? CntW'(MaxRegions) : CntW'(capacity);
  assign count = CntW'($countones(cell_valid));
  assign can_store = (count < cap_eff);
  assign any_hit = |cell_hit;

  // Priority pick of the first overlapping cell; cells from it on shift down.
  always_comb begin
    hit_rect = '0;
    shift_en = '0;
    hit_seen = 1'b0;
    for (int i = MaxRegions - 1; i >= 0; i--) begin
      if (cell_hit[i]) hit_rect = cell_rect[i];
    end
    for (int i = 0; i < MaxRegions; i++) begin
      hit_seen = hit_seen | cell_hit[i];
      shift_en[i] = (state == StMerge) && hit_seen;
      take_up[i] = 1'b1;
      append_here[i] = (CntW'(i) == count);
    end
  end

  assign ctrl.clear = (state == StIdle) && s_axis_tvalid && s_axis_tready &&
                      (s_axis_tdata[1:0] == OpClear);
  assign ctrl.append = (state == StMerge) && !any_hit && (op == OpAdd) && can_store;

  genvar g;
  generate
    for (g = 0; g < MaxRegions; g++) begin : g_cell
      rect_t up_r;
      logic up_v;
      if (g == MaxRegions - 1) begin : g_last
        assign up_r = cell_rect[g];
        assign up_v = 1'b0;
      end else begin : g_mid
        assign up_r = cell_rect[g+1];
        assign up_v = cell_valid[g+1];
      end
      drml_cell u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl), .take_up(take_up[g]),
        .shift(shift_en[g]), .append_here(append_here[g]), .probe(probe),
        .up_rect(up_r), .up_valid(up_v), .rect(cell_rect[g]),
        .valid(cell_valid[g]), .hit(cell_hit[g])
      );
    end
  endgenerate

  assign s_axis_tready = (state == StIdle) && !m_axis_tvalid;

  // Sequencer: accept, merge an add until no cell overlaps, then build the result; reads and clears go straight to it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op <= s_axis_tdata[1:0];
            probe <= {s_axis_tdata[17:2], s_axis_tdata[33:18],
                      s_axis_tdata[49:34], s_axis_tdata[65:50]};
            rd_idx <= s_axis_tdata[69:66];
            state <= (s_axis_tdata[1:0] == OpAdd) ? StMerge : StDone;
          end
        end
        StMerge: begin
          if (any_hit) begin
            probe.x0 <= (hit_rect.x0 < probe.x0) ? hit_rect.x0 : probe.x0;
            probe.y0 <= (hit_rect.y0 < probe.y0) ? hit_rect.y0 : probe.y0;
            probe.x1 <= (hit_rect.x1 > probe.x1) ? hit_rect.x1 : probe.x1;
            probe.y1 <= (hit_rect.y1 > probe.y1) ? hit_rect.y1 : probe.y1;
          end else begin
            // The count reported includes the entry appended in this cycle.
            m_axis_tdata <= {2'b0, 64'b0, count + CntW'(can_store), can_store};
            m_axis_tvalid <= 1'b1;
            state <= StIdle;
          end
        end
        StDone: begin
          m_axis_tvalid <= 1'b1;
          state <= StIdle;
          if (op == OpRead && cell_valid[rd_idx]) begin
            m_axis_tdata <= {2'b0, cell_rect[rd_idx].y1, cell_rect[rd_idx].x1,
                             cell_rect[rd_idx].y0, cell_rect[rd_idx].x0, count, 1'b1};
          end else begin
            m_axis_tdata <= {2'b0, 64'b0, count, (op == OpClear)};
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

// File: sv/drml_cell.sv
// One list cell: holds a rectangle, tests it against the probe, and shifts down.
`timescale 1ns / 1ps
module drml_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  drml_pkg::cell_ctrl_t ctrl,
  input  logic                 take_up,
  input  logic                 shift,
  input  logic                 append_here,
  input  drml_pkg::rect_t      probe,
  input  drml_pkg::rect_t      up_rect,
  input  logic                 up_valid,
  output drml_pkg::rect_t      rect,
  output logic                 valid,
  output logic                 hit
);
  import drml_pkg::*;

  // Inclusive overlap test against the probe rectangle.
  assign hit = valid && (rect.x1 >= probe.x0) && (rect.x0 <= probe.x1) &&
               (rect.y1 >= probe.y0) && (rect.y0 <= probe.y1);

  // Valid flag: cleared on clear, refilled from the upper neighbor on shift, set on append.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= up_valid;
    end else if (ctrl.append && append_here) begin
      valid <= 1'b1;
    end
  end

  // Payload: shift takes the neighbor's entry, append takes the probe.
  always_ff @(posedge clk) begin
    if (shift && take_up) begin
      rect <= up_rect;
    end else if (ctrl.append && append_here) begin
      rect <= probe;
    end
  end
endmodule

// File: bench/tb_dirty_region_merge_list.sv
// Testbench for the dirty-region merge list: directed and random stream traffic.
`timescale 1ns / 1ps
module tb_dirty_region_merge_list;
  import drml_pkg::*;

  localparam int StallPct = 16;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [15:0] y1;
    logic signed [15:0] x1;
    logic signed [15:0] y0;
    logic signed [15:0] x0;
    logic [4:0]         count;
    logic               ok;
  } region_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // opcode, left_x, top_y, right_x, bottom_y, read_index (lowest bit up)
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // accepted, entry_count, out_left_x, out_top_y, out_right_x, out_bottom_y
  logic [71:0] m_axis_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  // Predicted list state.
  rect_t          model_list[MaxRegions];
  int             model_count;
  int             model_cap;
  region_reply_t  expected_replies[$];

  int  error_count = 0;
  int  idle_cycles = 0;
  int  items_sent = 0;
  int  replies_seen = 0;
  bit  no_stall = 1'b0;

  dirty_region_merge_list DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Reply prediction; on add: grow over every touching entry, restarting each time.
  function automatic region_reply_t predict_region_op(logic [1:0] op, rect_t r,
                                                      logic [3:0] idx);
    region_reply_t rep;
    bit merged;
    int cap;
    rep = '0;
    if (op == OpAdd) begin
      cap = (model_cap > MaxRegions) ? MaxRegions : model_cap;
      do begin
        merged = 1'b0;
        for (int i = 0; i < model_count; i++) begin
          if (model_list[i].x1 >= r.x0 && model_list[i].x0 <= r.x1 &&
              model_list[i].y1 >= r.y0 && model_list[i].y0 <= r.y1) begin
            if (model_list[i].x0 < r.x0) r.x0 = model_list[i].x0;
            if (model_list[i].y0 < r.y0) r.y0 = model_list[i].y0;
            if (model_list[i].x1 > r.x1) r.x1 = model_list[i].x1;
            if (model_list[i].y1 > r.y1) r.y1 = model_list[i].y1;
            for (int j = i; j + 1 < model_count; j++) model_list[j] = model_list[j+1];
            model_count--;
            merged = 1'b1;
            break;
          end
        end
      end while (merged);
      if (model_count < cap) begin
        model_list[model_count] = r;
        model_count++;
        rep.ok = 1'b1;
      end
    end else if (op == OpRead) begin
      if (idx < model_count) begin
        rep.ok = 1'b1;
        rep.x0 = model_list[idx].x0;
        rep.y0 = model_list[idx].y0;
        rep.x1 = model_list[idx].x1;
        rep.y1 = model_list[idx].y1;
      end
    end else if (op == OpClear) begin
      model_count = 0;
      rep.ok = 1'b1;
    end
    rep.count = model_count[4:0];
    return rep;
  endfunction

  // Send one item, with random gaps before it; valid stays up after the transfer
  // until the next item or an explicit release.
  task automatic send_item(logic [1:0] op, rect_t r, logic [3:0] idx);
    while (!no_stall && $urandom_range(99) < StallPct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, idx, r.y1, r.x1, r.y0, r.x0, op};
    expected_replies.push_back(predict_region_op(op, r, idx));
    items_sent++;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_add(int x0, int y0, int x1, int y1);
    rect_t r;
    r.x0 = 16'(x0); r.y0 = 16'(y0); r.x1 = 16'(x1); r.y1 = 16'(y1);
    send_item(OpAdd, r, 4'd0);
  endtask

  task automatic send_read(logic [3:0] idx);
    send_item(OpRead, '0, idx);
  endtask

  task automatic send_clear();
    send_item(OpClear, '0, 4'd0);
  endtask

  // Write the capacity once the block has drained.
  task automatic write_capacity(logic [4:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    model_cap = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Reply checker and output back-pressure.
  always @(posedge clk) begin
    region_reply_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[69:0];
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply %h", $time, got);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            $display("%0t: reply mismatch expected %h actual %h", $time, want, got);
            error_count++;
          end
        end
      end
      m_axis_tready <= no_stall || ($urandom_range(99) >= StallPct);
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return $signed(16'($urandom()));
      default: return int'($urandom_range(60)) - 30;
    endcase
  endfunction

  task automatic test_edges();
    send_add(-32768, -32768, -32768, -32768);
    send_add(32767, 32767, 32767, 32767);
    send_add(-32767, -32767, -32767, -32767); // next to the first corner, no merge
    send_read(4'd0);
    send_read(4'd1);
    send_read(4'd15);                         // out of range
    send_add(10, 10, 5, 5);                   // inverted rectangle
    send_add(0, 0, 3, 3);
    send_add(4, 0, 6, 3);                     // shares no column, no merge
    send_add(3, 3, 4, 4);                     // bridges two entries
    send_read(4'd2);
    send_read(4'd3);
    send_item(2'd3, '0, 4'd0);                // unused opcode
    send_clear();
    send_read(4'd0);
  endtask

  task automatic test_capacity();
    write_capacity(5'd1);
    send_add(0, 0, 1, 1);
    send_add(100, 100, 101, 101);             // rejected, list full
    write_capacity(5'd0);
    send_add(0, 1, 2, 2);                     // merges, then rejected
    send_read(4'd0);
    write_capacity(5'd31);                    // above the list size
    for (int i = 0; i < 18; i++) send_add(i * 4, 0, i * 4 + 1, 1);
    send_read(4'd15);
    write_capacity(5'd3);
    send_add(0, 0, 5, 0);                     // merges with list still full
    send_clear();
  endtask

  task automatic test_random(int n);
    rect_t r;
    int u;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) no_stall = 1'b1;
      if (i == n / 2) no_stall = 1'b0;
      if (i % 200 == 199) write_capacity(5'($urandom_range(1, 31)));
      u = $urandom_range(99);
      if (u < 60) begin
        r.x0 = 16'(rand_coord()); r.y0 = 16'(rand_coord());
        if ($urandom_range(9) < 8) begin
          r.x1 = 16'(r.x0 + $urandom_range(6)); r.y1 = 16'(r.y0 + $urandom_range(6));
          if (r.x1 < r.x0) r.x1 = r.x0;
          if (r.y1 < r.y0) r.y1 = r.y0;
        end else begin
          r.x1 = 16'(rand_coord()); r.y1 = 16'(rand_coord());
        end
        send_item(OpAdd, r, 4'($urandom()));
      end else if (u < 94) begin
        r.x0 = 16'($urandom()); r.y0 = 16'($urandom());
        r.x1 = 16'($urandom()); r.y1 = 16'($urandom());
        send_item(OpRead, r, 4'($urandom()));
      end else if (u < 98) begin
        send_clear();
      end else begin
        send_item(2'd3, '0, 4'($urandom()));
      end
    end
  endtask

  initial begin
    model_count = 0;
    model_cap = 16;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_capacity();
    write_capacity(5'd16);
    test_random(850);
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d items and %0d replies over adds, reads, clears and", items_sent,
             replies_seen);
    $display("capacity settings from 0 to 31 with random stalls on both sides.");
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
sv/drml_pkg.sv
sv/drml_cell.sv
sv/dirty_region_merge_list.sv
bench/tb_dirty_region_merge_list.sv
